[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Both macros sample on clk and are
// disabled while arst_n is low, so they expect those names in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TLL_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tll assertion failed");
`define TLL_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tll assertion failed");
`else
`define TLL_ASSERT_IMP(name, ante, cons)
`define TLL_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[rtl/tll_pkg.sv]
// ----------------------------------------------------------------------------
// tll_pkg
// Token classes, character codes, record types and the classification
// functions of the tiny language lexer.
// ----------------------------------------------------------------------------
package tll_pkg;

	typedef enum logic [4:0] {
		CLS_SEMI   = 5'd0,
		CLS_IF     = 5'd1,
		CLS_THEN   = 5'd2,
		CLS_END    = 5'd3,
		CLS_REPEAT = 5'd4,
		CLS_UNTIL  = 5'd5,
		CLS_ASSIGN = 5'd6,
		CLS_READ   = 5'd7,
		CLS_WRITE  = 5'd8,
		CLS_LESS   = 5'd9,
		CLS_EQUAL  = 5'd10,
		CLS_PLUS   = 5'd11,
		CLS_MINUS  = 5'd12,
		CLS_MULT   = 5'd13,
		CLS_DIV    = 5'd14,
		CLS_OPEN   = 5'd15,
		CLS_CLOSE  = 5'd16,
		CLS_NUMBER = 5'd17,
		CLS_IDENT  = 5'd18,
		CLS_ERROR  = 5'd19
	} tok_class_t;

	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG9   = 8'h39;
	localparam logic [7:0] CH_UPPA   = 8'h41;
	localparam logic [7:0] CH_LOWZ   = 8'h7A;

	localparam int PREFIX_DEPTH = 6;
	localparam int QUEUE_DEPTH  = 4;

	typedef struct packed {
		tok_class_t  cls;
		logic [31:0] start;
		logic [7:0]  len;
	} token_t;

	// One queue entry holds everything a single byte produced: an optional
	// word token followed by an optional symbol token.
	typedef struct packed {
		logic   w_valid;
		token_t w;
		logic   s_valid;
		token_t s;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic       valid;
		tok_class_t cls;
	} sym_t;

	function automatic logic is_special(input logic [7:0] c);
		return c == CH_SEMI || c == CH_COLON || c == CH_EQ || c == CH_LT ||
			c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_LPAREN || c == CH_RPAREN || c == CH_SPACE || c == CH_LF ||
			c == CH_CR || c == CH_LBRACE || c == CH_RBRACE;
	endfunction

	function automatic sym_t symbol_class(input logic [7:0] c);
		sym_t s;
		s.valid = 1'b1;
		unique case (c)
			CH_SEMI:   s.cls = CLS_SEMI;
			CH_LT:     s.cls = CLS_LESS;
			CH_EQ:     s.cls = CLS_EQUAL;
			CH_PLUS:   s.cls = CLS_PLUS;
			CH_MINUS:  s.cls = CLS_MINUS;
			CH_STAR:   s.cls = CLS_MULT;
			CH_SLASH:  s.cls = CLS_DIV;
			CH_LPAREN: s.cls = CLS_OPEN;
			CH_RPAREN: s.cls = CLS_CLOSE;
			default: begin
				s.valid = 1'b0;
				s.cls   = CLS_ERROR;
			end
		endcase
		return s;
	endfunction

	// slen is the word length clipped to 7, so any long word misses every keyword.
	function automatic tok_class_t word_class(input logic [5:0][7:0] pre,
		input logic [2:0] slen);
		tok_class_t cls;
		if (pre[0] >= CH_DIG0 && pre[0] <= CH_DIG9)
			cls = CLS_NUMBER;
		else if (pre[0] >= CH_UPPA && pre[0] <= CH_LOWZ)
			cls = CLS_IDENT;
		else
			cls = CLS_ERROR;
		priority if (slen == 3'd2 && {pre[0], pre[1]} == "if")
			cls = CLS_IF;
		else if (slen == 3'd4 && {pre[0], pre[1], pre[2], pre[3]} == "then")
			cls = CLS_THEN;
		else if (slen == 3'd3 && {pre[0], pre[1], pre[2]} == "end")
			cls = CLS_END;
		else if (slen == 3'd6 && {pre[0], pre[1], pre[2], pre[3], pre[4], pre[5]}
				== "repeat")
			cls = CLS_REPEAT;
		else if (slen == 3'd5 && {pre[0], pre[1], pre[2], pre[3], pre[4]} == "until")
			cls = CLS_UNTIL;
		else if (slen == 3'd4 && {pre[0], pre[1], pre[2], pre[3]} == "read")
			cls = CLS_READ;
		else if (slen == 3'd5 && {pre[0], pre[1], pre[2], pre[3], pre[4]} == "write")
			cls = CLS_WRITE;
		else
			cls = cls;
		return cls;
	endfunction

endpackage

[rtl/tll_front.sv]
// ----------------------------------------------------------------------------
// tll_front
// Scanner state: takes one text byte per beat, tracks words, comments and
// colons, and builds the tokens that byte produces.
// ----------------------------------------------------------------------------
module tll_front import tll_pkg::*; #(
	parameter int MAX_TOKEN_LENGTH = 255,
	parameter int OFFSET_BITS      = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	input  qstat_t     qstat,
	output logic       push,
	output rec_t       push_rec
);

	localparam int CW = $clog2(MAX_TOKEN_LENGTH + 1);

	logic                   in_comment_q;
	logic                   colon_q;
	logic [OFFSET_BITS-1:0] colon_off_q;
	logic [CW-1:0]          cnt_q;
	logic [OFFSET_BITS-1:0] word_off_q;
	logic [5:0][7:0]        prefix_q;
	logic [OFFSET_BITS-1:0] byte_off_q;

	logic                   accept;
	logic                   sp;
	sym_t                   sym;
	logic                   assign_path;
	logic                   main_path;
	logic                   word_path;
	logic                   flush_now;
	logic                   emit_word;
	logic [CW-1:0]          cnt_n;
	logic [CW-1:0]          cnt_w;
	logic [16:0]            cnt_ext;
	logic [5:0][7:0]        prefix_n;
	logic [OFFSET_BITS-1:0] word_off_n;
	logic                   in_comment_n;
	logic                   colon_n;
	logic [OFFSET_BITS-1:0] colon_off_n;

	assign text_stall = qstat.full;
	assign accept     = text_valid && !qstat.full;

	assign sp          = is_special(char_code);
	assign sym         = symbol_class(char_code);
	assign assign_path = !in_comment_q && colon_q && char_code == CH_EQ;
	assign main_path   = !in_comment_q && !assign_path;
	assign word_path   = main_path && !sp;
	assign flush_now   = main_path && sp && cnt_q != '0;

	always_comb begin
		prefix_n = prefix_q;
		if (word_path) begin
			cnt_n = (cnt_q < CW'(MAX_TOKEN_LENGTH)) ? cnt_q + CW'(1) : cnt_q;
			if (cnt_q < CW'(PREFIX_DEPTH))
				prefix_n[cnt_q[2:0]] = char_code;
		end else if (main_path) begin
			cnt_n = '0;
		end else begin
			cnt_n = cnt_q;
		end
	end

	assign word_off_n = (word_path && cnt_q == '0) ? byte_off_q : word_off_q;

	// A special byte ends the pending word; otherwise end of text flushes
	// the word including this byte.
	assign emit_word = flush_now || (end_of_text && cnt_n != '0);
	assign cnt_w     = flush_now ? cnt_q : cnt_n;
	assign cnt_ext   = 17'(cnt_w);

	always_comb begin
		push_rec.w_valid   = emit_word;
		push_rec.w.cls     = word_class(prefix_n,
			(cnt_ext > 17'd6) ? 3'd7 : cnt_ext[2:0]);
		push_rec.w.start   = 32'(word_off_n);
		push_rec.w.len     = (cnt_ext > 17'd255) ? 8'hFF : cnt_ext[7:0];
		push_rec.s_valid   = assign_path || (main_path && sp && sym.valid);
		if (assign_path) begin
			push_rec.s.cls   = CLS_ASSIGN;
			push_rec.s.start = 32'(colon_off_q);
			push_rec.s.len   = 8'd2;
		end else begin
			push_rec.s.cls   = sym.cls;
			push_rec.s.start = 32'(byte_off_q);
			push_rec.s.len   = 8'd1;
		end
	end

	assign push = accept && (push_rec.w_valid || push_rec.s_valid);

	always_comb begin
		in_comment_n = in_comment_q;
		if (in_comment_q)
			in_comment_n = char_code != CH_RBRACE;
		else if (main_path && char_code == CH_LBRACE)
			in_comment_n = 1'b1;
		colon_n     = main_path && char_code == CH_COLON;
		colon_off_n = colon_n ? byte_off_q : colon_off_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			colon_q      <= 1'b0;
			colon_off_q  <= '0;
			cnt_q        <= '0;
			word_off_q   <= '0;
			byte_off_q   <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				in_comment_q <= 1'b0;
				colon_q      <= 1'b0;
				colon_off_q  <= '0;
				cnt_q        <= '0;
				word_off_q   <= '0;
				byte_off_q   <= '0;
			end else begin
				in_comment_q <= in_comment_n;
				colon_q      <= colon_n;
				colon_off_q  <= colon_off_n;
				cnt_q        <= cnt_n;
				word_off_q   <= word_off_n;
				byte_off_q   <= byte_off_q + OFFSET_BITS'(1);
			end
		end
	end

	// Only entries already written for the current word are ever read.
	always_ff @(posedge clk) begin
		if (accept)
			prefix_q <= prefix_n;
	end

endmodule

[rtl/tll_queue.sv]
// ----------------------------------------------------------------------------
// tll_queue
// Short first-in first-out queue of per-byte token records between the
// scanner and the output stage.
// ----------------------------------------------------------------------------
module tll_queue import tll_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  rec_t   push_rec,
	input  logic   pop,
	output rec_t   head,
	output qstat_t qstat
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	rec_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = count_q == (PW + 1)'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + (PW + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PW + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_rec;
	end

endmodule

[rtl/tll_back.sv]
// ----------------------------------------------------------------------------
// tll_back
// Output stage: splits each queued record into one or two token beats and
// holds them in the output register while the receiver stalls.
// ----------------------------------------------------------------------------
module tll_back import tll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rec_t        head,
	input  qstat_t      qstat,
	output logic        pop,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [4:0]  token_class,
	output logic [31:0] token_start,
	output logic [7:0]  token_length,
	output logic        last_in_run
);

	logic   phase_q;
	logic   valid_q;
	token_t tok_q;
	logic   last_q;
	logic   load;
	logic   take_s;
	token_t pick;
	logic   pick_last;

	assign load   = !valid_q || !token_stall;
	// The symbol slot is sent once the word slot is done or when there is none.
	assign take_s = phase_q || !head.w_valid;
	assign pop    = load && !qstat.empty && (take_s || !head.s_valid);

	always_comb begin
		if (take_s) begin
			pick      = head.s;
			pick_last = 1'b1;
		end else begin
			pick      = head.w;
			pick_last = !head.s_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !qstat.empty;
			if (!qstat.empty)
				phase_q <= !pop;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qstat.empty) begin
			tok_q  <= pick;
			last_q <= pick_last;
		end
	end

	assign token_valid  = valid_q;
	assign token_class  = tok_q.cls;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.len;
	assign last_in_run  = last_q;

endmodule

[rtl/tiny_language_lexer_top.sv]
// Tiny language lexer.
// The text channel (text_valid, text_stall, char_code, end_of_text) takes
// one source byte per beat; end_of_text marks the final byte, after which
// the pending word is flushed and the next byte starts a new text at
// offset 0. The token channel (token_valid, token_stall) gives one token
// per beat with class, start offset, length and last_in_run, which marks
// the last token caused by one text byte.
// A token is registered in the record queue and then in the output register.
// Throughput: one byte per cycle while text_stall is low, one token per
// cycle while token_stall is low; a byte that causes two tokens sends them
// in turn, and a four-entry record queue between the scanner and the output
// stage absorbs such bursts. text_stall rises only when that queue is full.
// When the receiver stalls, the output register holds its token and the
// scanner keeps accepting bytes until the queue fills.
// Reset clears the scanner state, empties the queue and clears token_valid.
// ----------------------------------------------------------------------------
// tiny_language_lexer_top
// Top level: scanner, record queue and token output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tiny_language_lexer_top import tll_pkg::*; #(
	parameter int MAX_TOKEN_LENGTH = 255,
	parameter int OFFSET_BITS      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [4:0]  token_class,
	output logic [31:0] token_start,
	output logic [7:0]  token_length,
	output logic        last_in_run
);

	qstat_t qstat;
	logic   push;
	rec_t   push_rec;
	logic   pop;
	rec_t   head;

	tll_front #(
		.MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
		.OFFSET_BITS     (OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.qstat      (qstat),
		.push       (push),
		.push_rec   (push_rec)
	);

	tll_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	tll_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_class (token_class),
		.token_start (token_start),
		.token_length(token_length),
		.last_in_run (last_in_run)
	);

	`TLL_ASSERT_IMP(a_no_push_full, push, !qstat.full)
	`TLL_ASSERT_IMP(a_no_pop_empty, pop, !qstat.empty)
	`TLL_ASSERT_IMP(a_head_has_token, !qstat.empty, head.w_valid || head.s_valid)
	`TLL_ASSERT_NEXT(a_push_fills, push && !pop, !qstat.empty)

endmodule

[verif/tiny_language_lexer_top_tb.sv]
// ----------------------------------------------------------------------------
// tiny_language_lexer_top_tb
// Self-checking bench for the tiny language lexer. Source text goes in
// one byte per beat, and a scanner model in the bench predicts every token.
// Each token taken from the block is compared field by field with the
// oldest prediction. The text starts with a short directed stretch, then
// comes mostly well-formed program text mixed with noise. It runs through
// several phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module tiny_language_lexer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tll_pkg::*;

	localparam int MAX_WORD       = 255;
	localparam int QUIET_LIMIT    = 3000;
	localparam int HOLDOFF_AT     = 10;
	localparam int HOLDOFF_CYCLES = 100;
	localparam int PRINT_LIMIT    = 40;

	typedef struct packed {
		logic [7:0] code;
		logic       eot;
	} text_beat_t;

	typedef struct packed {
		tok_class_t  cls;
		logic [31:0] start;
		logic [7:0]  len;
		logic        last;
	} token_rec_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        text_valid   = 1'b0;
	logic        text_stall;
	logic [7:0]  char_code    = 8'd0;
	logic        end_of_text  = 1'b0;
	logic        token_valid;
	logic        token_stall  = 1'b0;
	logic [4:0]  token_class;
	logic [31:0] token_start;
	logic [7:0]  token_length;
	logic        last_in_run;

	text_beat_t source_bytes[$];
	token_rec_t pending_tokens[$];
	token_rec_t step_hits[$];
	text_beat_t next_beat;

	int bytes_queued   = 0;
	int bytes_taken    = 0;
	int tokens_seen    = 0;
	int mismatches     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_left   = 0;
	int quiet_cycles   = 0;

	// Scanner state of the prediction.
	logic        scan_in_comment = 1'b0;
	logic        scan_colon      = 1'b0;
	logic [31:0] scan_colon_at   = 32'd0;
	int          scan_word_len   = 0;
	logic [31:0] scan_word_at    = 32'd0;
	logic [7:0]  scan_prefix [6];
	logic [31:0] scan_pos        = 32'd0;

	string      keywords [7] = '{"if", "then", "end", "repeat", "until", "read", "write"};
	logic [7:0] symbol_bytes [10] = '{CH_SEMI, CH_LT, CH_EQ, CH_PLUS, CH_MINUS, CH_STAR,
		CH_SLASH, CH_LPAREN, CH_RPAREN, CH_RBRACE};

	tiny_language_lexer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.char_code    (char_code),
		.end_of_text  (end_of_text),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_class  (token_class),
		.token_start  (token_start),
		.token_length (token_length),
		.last_in_run  (last_in_run)
	);

	always #5 clk = ~clk;

	function automatic bit is_delim(input logic [7:0] c);
		case (c)
			CH_SEMI, CH_COLON, CH_EQ, CH_LT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
			CH_LPAREN, CH_RPAREN, CH_SPACE, CH_LF, CH_CR, CH_LBRACE, CH_RBRACE: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit symbol_of(input logic [7:0] c, output tok_class_t cls);
		cls = CLS_ERROR;
		case (c)
			CH_SEMI:   cls = CLS_SEMI;
			CH_LT:     cls = CLS_LESS;
			CH_EQ:     cls = CLS_EQUAL;
			CH_PLUS:   cls = CLS_PLUS;
			CH_MINUS:  cls = CLS_MINUS;
			CH_STAR:   cls = CLS_MULT;
			CH_SLASH:  cls = CLS_DIV;
			CH_LPAREN: cls = CLS_OPEN;
			CH_RPAREN: cls = CLS_CLOSE;
			default:   return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Only prefix entries written for the current word are compared.
	function automatic bit word_is(input string kw);
		int i;
		if (kw.len() != scan_word_len)
			return 1'b0;
		for (i = 0; i < kw.len(); i++)
			if (scan_prefix[i] != kw[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic tok_class_t classify_word();
		if (word_is("if"))     return CLS_IF;
		if (word_is("then"))   return CLS_THEN;
		if (word_is("end"))    return CLS_END;
		if (word_is("repeat")) return CLS_REPEAT;
		if (word_is("until"))  return CLS_UNTIL;
		if (word_is("read"))   return CLS_READ;
		if (word_is("write"))  return CLS_WRITE;
		if (scan_prefix[0] >= CH_DIG0 && scan_prefix[0] <= CH_DIG9)
			return CLS_NUMBER;
		if (scan_prefix[0] >= CH_UPPA && scan_prefix[0] <= CH_LOWZ)
			return CLS_IDENT;
		return CLS_ERROR;
	endfunction

	task automatic close_word();
		if (scan_word_len != 0) begin
			step_hits.insert(step_hits.size(), '{classify_word(), scan_word_at,
				8'(scan_word_len > 255 ? 255 : scan_word_len), 1'b0});
			scan_word_len = 0;
		end
	endtask

	// Advances the scanner model by one accepted byte and queues the tokens it makes.
	task automatic scan_byte(input logic [7:0] c, input logic eot);
		tok_class_t  cls;
		logic [31:0] here;
		here = scan_pos;
		step_hits.delete();
		if (scan_in_comment) begin
			if (c == CH_RBRACE)
				scan_in_comment = 1'b0;
		end else if (scan_colon && c == CH_EQ) begin
			scan_colon = 1'b0;
			step_hits.insert(step_hits.size(), '{CLS_ASSIGN, scan_colon_at, 8'd2, 1'b0});
		end else begin
			scan_colon = 1'b0;
			if (is_delim(c)) begin
				close_word();
				if (c == CH_COLON) begin
					scan_colon    = 1'b1;
					scan_colon_at = here;
				end else if (c == CH_LBRACE) begin
					scan_in_comment = 1'b1;
				end else if (symbol_of(c, cls)) begin
					step_hits.insert(step_hits.size(), '{cls, here, 8'd1, 1'b0});
				end
			end else begin
				if (scan_word_len == 0)
					scan_word_at = here;
				if (scan_word_len < 6)
					scan_prefix[scan_word_len] = c;
				if (scan_word_len < MAX_WORD)
					scan_word_len++;
			end
		end
		// The final byte flushes the word and starts the next text at offset zero.
		if (eot) begin
			close_word();
			scan_in_comment = 1'b0;
			scan_colon      = 1'b0;
			scan_colon_at   = 32'd0;
			scan_word_at    = 32'd0;
			scan_pos        = 32'd0;
		end else begin
			scan_pos = scan_pos + 32'd1;
		end
		if (step_hits.size() != 0)
			step_hits[step_hits.size() - 1].last = 1'b1;
		foreach (step_hits[i])
			pending_tokens.insert(pending_tokens.size(), step_hits[i]);
	endtask

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: token %0d: %s", $realtime, tokens_seen, msg);
	endtask

	task automatic check_token();
		token_rec_t want;
		if (pending_tokens.size() == 0) begin
			report($sformatf("unexpected token class %0d start %0d length %0d",
				token_class, token_start, token_length));
		end else begin
			want = pending_tokens.pop_front();
			if (token_class !== want.cls)
				report($sformatf("class %0d, expected %0d", token_class, want.cls));
			if (token_start !== want.start)
				report($sformatf("start %0d, expected %0d", token_start, want.start));
			if (token_length !== want.len)
				report($sformatf("length %0d, expected %0d", token_length, want.len));
			if (last_in_run !== want.last)
				report($sformatf("last_in_run %0b, expected %0b", last_in_run, want.last));
		end
		tokens_seen++;
	endtask

	task automatic push_byte(input logic [7:0] c, input logic eot = 1'b0);
		source_bytes.insert(source_bytes.size(), '{c, eot});
		bytes_queued++;
	endtask

	task automatic push_text(input string s, input logic eot_last = 1'b0);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], eot_last && i == s.len() - 1);
	endtask

	function automatic logic [7:0] word_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (is_delim(c));
		return c;
	endfunction

	task automatic maybe_space();
		if ($urandom_range(9) < 6)
			push_byte(CH_SPACE);
	endtask

	// Mostly well-formed program text, with some noise and texts cut short.
	task automatic add_random_text(input int budget);
		int    stop;
		int    kind;
		string kw;
		stop = bytes_queued + budget;
		while (bytes_queued < stop) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				push_text(keywords[$urandom_range(6)]);
				maybe_space();
			end else if (kind < 25) begin
				kw = keywords[$urandom_range(6)];
				if ($urandom_range(1))
					push_text({kw, "s"});
				else
					push_text(kw.substr(0, kw.len() - 2));
				maybe_space();
			end else if (kind < 40) begin
				push_byte(8'($urandom_range(CH_UPPA, CH_LOWZ)));
				repeat ($urandom_range(0, 7)) push_byte(word_byte());
				maybe_space();
			end else if (kind < 50) begin
				push_byte(8'($urandom_range(CH_DIG0, CH_DIG9)));
				repeat ($urandom_range(0, 5)) push_byte(word_byte());
				maybe_space();
			end else if (kind < 65) begin
				push_byte(symbol_bytes[$urandom_range(9)]);
			end else if (kind < 71) begin
				push_byte(CH_COLON);
				push_byte(CH_EQ);
			end else if (kind < 74) begin
				push_byte(CH_COLON);
			end else if (kind < 79) begin
				push_byte(CH_LBRACE);
				repeat ($urandom_range(0, 6))
					push_byte($urandom_range(3) == 0 ? CH_LBRACE : word_byte());
				push_byte(CH_RBRACE);
			end else if (kind < 91) begin
				case ($urandom_range(2))
					0: push_byte(CH_SPACE);
					1: push_byte(CH_CR);
					default: push_byte(CH_LF);
				endcase
			end else if (kind < 97) begin
				push_byte(8'($urandom_range(255)));
			end else begin
				push_byte(8'($urandom_range(255)), 1'b1);
			end
		end
	endtask

	// Holds the sender back until every byte is taken and every token has come.
	task automatic drain();
		while (bytes_taken != bytes_queued)
			@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	// Text driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid  <= 1'b0;
			char_code   <= 8'd0;
			end_of_text <= 1'b0;
		end else begin
			if (text_valid && !text_stall) begin
				scan_byte(char_code, end_of_text);
				bytes_taken++;
			end
			if (!text_valid || !text_stall) begin
				if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = source_bytes.pop_front();
					text_valid  <= 1'b1;
					char_code   <= next_beat.code;
					end_of_text <= next_beat.eot;
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// Token monitor. After a fixed number of tokens it holds off for a long
	// stretch so that the record queue fills and the text side stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_stall <= 1'b0;
		end else begin
			if (token_valid && !token_stall) begin
				check_token();
				if (tokens_seen == HOLDOFF_AT)
					holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				token_stall <= 1'b1;
			end else begin
				token_stall <= $urandom_range(99) < recv_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (token_valid && !token_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tiny_language_lexer_top_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Keyword, less, number, assign, identifier, lone colon before a semicolon.
		push_text("repeat<9:=A:;");
		// Non-ASCII word ended by a comment with a nested brace, a stray close
		// brace, line breaks, and a colon still pending at the end of the text.
		push_byte(8'hFF);
		push_text("{x{}}");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_COLON, 1'b1);
		// Comment left open at the end of the text.
		push_text("z{a", 1'b1);
		// A zero byte alone is a word of class error.
		push_byte(8'h00, 1'b1);
		push_text("(=)");
		add_random_text(60);
		drain();

		send_idle_pct = 61;
		add_random_text(40);
		drain();

		send_idle_pct  = 0;
		recv_stall_pct = 61;
		add_random_text(40);
		drain();

		send_idle_pct  = 22;
		recv_stall_pct = 22;
		add_random_text(10);
		// Word long enough to saturate the length.
		repeat ($urandom_range(256, 262)) push_byte(word_byte());
		push_byte(CH_SPACE);
		add_random_text(10);
		drain();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tiny_language_lexer_top_tb: done, clean");
		else
			$display("tiny_language_lexer_top_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/tll_pkg.sv
rtl/tll_front.sv
rtl/tll_queue.sv
rtl/tll_back.sv
rtl/tiny_language_lexer_top.sv
verif/tiny_language_lexer_top_tb.sv
